// File: rtl/core/spq_pkg.sv
package spq_pkg;

	// Queue depth and stored priority width
	localparam int CAPACITY      = 16;
	localparam int PRIORITY_BITS = 16;
	localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

	// Request codes
	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// One held entry
	typedef struct packed {
		logic signed [31:0]              value;
		logic signed [PRIORITY_BITS-1:0] prio;
	} entry_t;

	// Broadcast to every cell for the current transaction
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t new_entry;
	} spq_ctrl_t;

endpackage

// File: rtl/core/spq_cell.sv
module spq_cell (
	input  logic               clk,
	input  spq_pkg::spq_ctrl_t ctrl,
	input  logic               occupied,
	input  spq_pkg::entry_t    prev_entry,
	input  logic               prev_greater,
	input  spq_pkg::entry_t    next_entry,
	output spq_pkg::entry_t    entry,
	output logic               greater
);
	import spq_pkg::*;

	entry_t entry_q;

	// An empty slot or a strictly larger priority lets the new entry in ahead
	assign greater = !occupied ||
		($signed(entry_q.prio) > $signed(ctrl.new_entry.prio));
	assign entry   = entry_q;

	// Shift right on insert, take new entry at the boundary, shift left on removal
	always_ff @(posedge clk) begin
		if (ctrl.enq && greater) begin
			if (prev_greater) begin
				entry_q <= prev_entry;
			end else begin
				entry_q <= ctrl.new_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= next_entry;
		end
	end

endmodule

// File: rtl/core/stable_priority_queue_core.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// request  | in_valid / in_ready | req_type, in_value, in_priority
// result   | out_valid/out_ready | out_value, out_priority, status, occupancy
//
// One request per cycle while in_ready is high: every cell compares its priority
// with the new one in parallel and moves one slot toward its neighbor, so the row
// settles in the accepting cycle. The result sits in an output register next cycle.
// in_ready stays high while the result register is empty or being drained.
// arst_n clears the entry count and the result valid; cell contents are not reset.
module stable_priority_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic signed [31:0] in_value,
	input  logic signed [15:0] in_priority,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] out_value,
	output logic signed [15:0] out_priority,
	output logic [1:0]  status,
	output logic [4:0]  occupancy
);
	import spq_pkg::*;

	logic [COUNT_BITS-1:0] count_q;
	logic                  out_valid_q;
	logic signed [31:0]    out_value_q;
	logic signed [15:0]    out_priority_q;
	status_t               status_q;
	logic [4:0]            occupancy_q;

	spq_ctrl_t             ctrl;
	entry_t                cell_entry [CAPACITY];
	logic                  cell_greater [CAPACITY];
	logic                  fire;
	logic                  is_deq;
	logic                  full;
	logic                  empty;
	logic [COUNT_BITS-1:0] count_d;
	status_t               status_d;

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;
	assign is_deq   = (req_t'(req_type) == REQ_DEQ);
	assign full     = (count_q == COUNT_BITS'(CAPACITY));
	assign empty    = (count_q == '0);

	// Transaction decode
	always_comb begin
		ctrl.enq             = fire && !is_deq && !full;
		ctrl.deq             = fire && is_deq && !empty;
		ctrl.new_entry.value = in_value;
		ctrl.new_entry.prio  = PRIORITY_BITS'(in_priority);
		count_d              = count_q;
		status_d             = ST_DONE;
		if (is_deq) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				count_d = count_q - 1'b1;
			end
		end else begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + 1'b1;
			end
		end
	end

	// Sorted row of cells, front at index 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_g;
		if (i == 0) begin : g_front
			assign prev_e = ctrl.new_entry;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_entry[i-1];
			assign prev_g = cell_greater[i-1];
		end
		if (i == CAPACITY - 1) begin : g_back
			assign next_e = cell_entry[i];
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end
		spq_cell u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.occupied     (COUNT_BITS'(i) < count_q),
			.prev_entry   (prev_e),
			.prev_greater (prev_g),
			.next_entry   (next_e),
			.entry        (cell_entry[i]),
			.greater      (cell_greater[i])
		);
	end

	// Entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			if (ctrl.deq) begin
				out_value_q    <= cell_entry[0].value;
				out_priority_q <= 16'($signed(cell_entry[0].prio));
			end else begin
				out_value_q    <= '0;
				out_priority_q <= '0;
			end
			status_q    <= status_d;
			occupancy_q <= 5'(count_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_priority = out_priority_q;
	assign status       = status_q;
	assign occupancy    = occupancy_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import spq_pkg::*;

	localparam int RANDOM_REQS = 450;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	// One pending request transaction
	typedef struct {
		req_t               kind;
		logic signed [31:0] value;
		logic signed [15:0] prio;
		bit                 wait_drain;
	} request_t;

	// One expected result transaction
	typedef struct {
		logic signed [31:0] value;
		logic signed [15:0] prio;
		status_t            st;
		logic [4:0]         occ;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic signed [31:0] in_value;
	logic signed [15:0] in_priority;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] out_value;
	logic signed [15:0] out_priority;
	logic [1:0]         status;
	logic [4:0]         occupancy;

	request_t pending_reqs[$];
	outcome_t expected_outcomes[$];
	request_t next_req;
	outcome_t want;

	// Shadow copy of the sorted store
	entry_t   held[CAPACITY];
	int       held_cnt;

	bit       req_taken;
	int       send_gap;
	int       recv_stall;
	int       accepted_cnt;
	int       cycle_cnt;
	int       mismatches;
	logic [1:0] idle_phase;

	stable_priority_queue_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.in_value    (in_value),
		.in_priority (in_priority),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.out_priority(out_priority),
		.status      (status),
		.occupancy   (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sorted insert behind equal priorities, pop from the front
	function automatic outcome_t apply_request(req_t kind, logic signed [31:0] value,
			logic signed [15:0] prio);
		outcome_t res;
		int pos;
		int i;
		res.value = '0;
		res.prio  = '0;
		res.st    = ST_DONE;
		if (kind == REQ_ENQ) begin
			if (held_cnt >= CAPACITY) begin
				res.st = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_cnt && $signed(held[pos].prio) <= prio)
					pos++;
				for (i = held_cnt; i > pos; i--)
					held[i] = held[i-1];
				held[pos].value = value;
				held[pos].prio  = prio;
				held_cnt++;
			end
		end else begin
			if (held_cnt == 0) begin
				res.st = ST_EMPTY;
			end else begin
				res.value = held[0].value;
				res.prio  = held[0].prio;
				for (i = 1; i < held_cnt; i++)
					held[i-1] = held[i];
				held_cnt--;
			end
		end
		res.occ = 5'(held_cnt);
		return res;
	endfunction

	// Mostly short idle stretches, a few long ones
	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic add_req(req_t kind, logic signed [31:0] value, logic signed [15:0] prio,
			bit wait_drain);
		request_t r;
		r.kind       = kind;
		r.value      = value;
		r.prio       = prio;
		r.wait_drain = wait_drain;
		pending_reqs.push_back(r);
	endtask

	task automatic report(string field, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
				exp_val, act_val);
		end
	endtask

	// Idling pattern cycles through none, sender only, receiver only, both
	assign idle_phase = 2'((accepted_cnt / 40) % 4);

	// Request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !req_taken) begin
				// transaction still waiting for acceptance
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 &&
					!(pending_reqs[0].wait_drain && expected_outcomes.size() > 0)) begin
				next_req = pending_reqs.pop_front();
				in_valid    <= 1'b1;
				req_type    <= next_req.kind;
				in_value    <= next_req.value;
				in_priority <= next_req.prio;
				if (idle_phase[0] && $urandom_range(0, 99) < 30)
					send_gap = pick_idle_len();
			end else begin
				in_valid <= 1'b0;
			end
			req_taken = 1'b0;
		end
	end

	// Result backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_phase[1] && $urandom_range(0, 99) < 25)
					recv_stall = pick_idle_len();
			end
		end
	end

	// Monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_cnt++;
			if (cycle_cnt > CYCLE_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual value %0h prio %0h",
						$time, out_value, out_priority);
				end else begin
					want = expected_outcomes.pop_front();
					report("out_value", want.value, out_value);
					report("out_priority", 32'(want.prio), 32'(out_priority));
					report("status", 32'(want.st), 32'(status));
					report("occupancy", 32'(want.occ), 32'(occupancy));
				end
			end
			if (in_valid && in_ready) begin
				expected_outcomes.push_back(apply_request(req_t'(req_type), in_value,
					in_priority));
				req_taken = 1'b1;
				accepted_cnt++;
			end
		end
	end

	initial begin
		int n;
		int enq_pct;
		int sel;
		req_t kind;
		logic signed [15:0] prio;
		logic signed [31:0] value;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		out_ready   = 1'b0;
		req_type    = REQ_ENQ;
		in_value    = '0;
		in_priority = '0;
		held_cnt    = 0;
		req_taken   = 1'b0;
		send_gap    = 0;
		recv_stall  = 0;
		accepted_cnt = 0;
		cycle_cnt   = 0;
		mismatches  = 0;

		// Directed: dequeue on empty, fill with extremes and ties, overflow, drain some
		add_req(REQ_DEQ, $urandom, 16'($urandom), 1'b0);
		add_req(REQ_ENQ, 32'sh7FFFFFFF, 16'sd0, 1'b0);
		add_req(REQ_ENQ, 32'sh80000000, 16'sh7FFF, 1'b0);
		add_req(REQ_ENQ, 32'sd0, 16'sh8000, 1'b0);
		add_req(REQ_ENQ, -32'sd1, 16'sd5, 1'b0);
		add_req(REQ_ENQ, 32'sd1, 16'sd5, 1'b0);
		add_req(REQ_ENQ, 32'sd2, 16'sd5, 1'b0);
		add_req(REQ_ENQ, 32'sh5555AAAA, -16'sd1, 1'b0);
		add_req(REQ_ENQ, 32'shAAAA5555, 16'sd1, 1'b0);
		add_req(REQ_ENQ, 32'sd3, 16'sh8000, 1'b0);
		add_req(REQ_ENQ, 32'sd4, 16'sh7FFF, 1'b0);
		add_req(REQ_ENQ, 32'sd5, 16'sd0, 1'b0);
		add_req(REQ_ENQ, 32'sd6, 16'sd100, 1'b0);
		add_req(REQ_ENQ, 32'sd7, -16'sd100, 1'b0);
		add_req(REQ_ENQ, 32'sd8, 16'sd5, 1'b0);
		add_req(REQ_ENQ, 32'sd9, 16'sd2, 1'b0);
		add_req(REQ_ENQ, 32'sd10, 16'sd3, 1'b0);
		add_req(REQ_ENQ, 32'sd11, 16'sh8000, 1'b0);
		add_req(REQ_DEQ, $urandom, 16'($urandom), 1'b0);
		add_req(REQ_DEQ, $urandom, 16'($urandom), 1'b0);
		add_req(REQ_DEQ, $urandom, 16'($urandom), 1'b0);
		add_req(REQ_ENQ, 32'sd12, 16'sh8000, 1'b0);
		add_req(REQ_DEQ, $urandom, 16'($urandom), 1'b0);

		// Random: blocks with different enqueue mix so the queue swings full and empty
		enq_pct = 50;
		for (n = 0; n < RANDOM_REQS; n++) begin
			if (n % 50 == 0) begin
				case ((n / 50) % 4)
					0: enq_pct = 85;
					1: enq_pct = 15;
					2: enq_pct = 55;
					default: enq_pct = 70;
				endcase
			end
			kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
			sel = $urandom_range(0, 9);
			if (sel < 4)
				prio = 16'($signed($urandom_range(0, 6)) - 3);
			else if (sel < 8)
				prio = 16'($urandom);
			else if (sel == 8)
				prio = 16'sh8000;
			else
				prio = 16'sh7FFF;
			sel = $urandom_range(0, 9);
			if (sel == 0)
				value = 32'sh80000000;
			else if (sel == 1)
				value = 32'sh7FFFFFFF;
			else
				value = $urandom;
			add_req(kind, value, prio, (n == 0) || (n == RANDOM_REQS / 2));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() > 0 || in_valid || expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// File: stable_priority_queue_core.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_core.sv
tb/tb_top.sv
